>>> rtl/core/onewire_temp_sensor_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// One-wire sensor sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_TEMP_SENSOR_SEQUENCER_CORE_DEFINES_SVH
`define ONEWIRE_TEMP_SENSOR_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define OWTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("owts: same-cycle check failed");

// next-cycle implication
`define OWTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("owts: next-cycle check failed");

`endif

>>> rtl/core/owts_pkg.sv
// ----------------------------------------------------------------------------
// One-wire sensor sequencer package
// Command, status and register codes, bus command bytes and the CRC-8 step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owts_pkg;

	localparam logic [1:0] KIND_INIT    = 2'd0;
	localparam logic [1:0] KIND_MEASURE = 2'd1;
	localparam logic [1:0] KIND_REPLY   = 2'd2;
	localparam logic [1:0] KIND_TICK    = 2'd3;

	localparam logic [1:0] ACT_RESET  = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;
	localparam logic [1:0] ACT_REPORT = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOPRES = 3'd1;
	localparam logic [2:0] ST_CRC    = 3'd2;
	localparam logic [2:0] ST_FAMILY = 3'd3;
	localparam logic [2:0] ST_INITOK = 3'd4;

	localparam logic [2:0] REG_ENABLE     = 3'd0;
	localparam logic [2:0] REG_ALARM_HIGH = 3'd1;
	localparam logic [2:0] REG_ALARM_LOW  = 3'd2;
	localparam logic [2:0] REG_RESOLUTION = 3'd3;
	localparam logic [2:0] REG_WAIT       = 3'd4;
	localparam logic [2:0] REG_FAMILY     = 3'd5;

	localparam logic [7:0] CMD_READ_ROM = 8'h33;
	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_WRITE_SP = 8'h4E;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_SP  = 8'hBE;

	localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
	localparam logic [3:0] SCRATCH_CRC_IDX = 4'd8;

	localparam logic [3:0] RES_9  = 4'd9;
	localparam logic [3:0] RES_10 = 4'd10;
	localparam logic [3:0] RES_11 = 4'd11;

	localparam logic [7:0] CFG_RES_9  = 8'h1F;
	localparam logic [7:0] CFG_RES_10 = 8'h3F;
	localparam logic [7:0] CFG_RES_11 = 8'h5F;
	localparam logic [7:0] CFG_RES_12 = 8'h7F;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] crc;
		logic [7:0] d;
		logic       mix;
		crc = crc_in;
		d   = data;
		for (int i = 0; i < 8; i++) begin
			mix = crc[0] ^ d[0];
			crc = crc >> 1;
			if (mix) begin
				crc = crc ^ CRC_POLY_REFL;
			end
			d = d >> 1;
		end
		return crc;
	endfunction

	function automatic logic [7:0] res_byte(input logic [3:0] bits);
		logic [7:0] b;
		case (bits)
			RES_9:   b = CFG_RES_9;
			RES_10:  b = CFG_RES_10;
			RES_11:  b = CFG_RES_11;
			default: b = CFG_RES_12;
		endcase
		return b;
	endfunction

endpackage

>>> rtl/core/onewire_temp_sensor_sequencer_core.sv
// ----------------------------------------------------------------------------
// One-wire temperature sensor sequencer core
// Byte-level command sequencer: init, measure, CRC-8 check and reporting.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_ready) carries start init, start measure, bus
//  replies from the byte engine and wait ticks. Each item yields zero or one
//  result on the output channel (out_valid/out_ready): a reset, write or read
//  command for the byte engine, or a report with status and temperature.
//  Configuration is written over cfg_valid/cfg_ready (always ready) by
//  register index; the user must write it only while the sequencer is idle,
//  which the block itself does not enforce. An accepted item is held in an
//  input register, where the state update and result are formed; the result
//  is then registered in the output register when that register is empty
//  or its result transfers. One item is taken per cycle while the receiver
//  accepts. When the receiver stalls, the output register holds its result
//  and the input register still takes one more item; in_ready then drops
//  until the result transfers.
//  Reset returns the sequencer to idle with default configuration and a
//  stored temperature of zero; nothing is emitted until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "onewire_temp_sensor_sequencer_core_defines.svh"

module onewire_temp_sensor_sequencer_core
	import owts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic               presence,
	input  logic [7:0]         read_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         action,
	output logic [7:0]         write_value,
	output logic signed [15:0] temperature,
	output logic [2:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [9:0]         cfg_data
);

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_I_RST, PH_I_ROMCMD, PH_I_FAMILY, PH_I_RST2,
		PH_I_SKIP, PH_I_WSP, PH_I_TH, PH_I_TL, PH_I_CFG,
		PH_M_RST, PH_M_SKIP, PH_M_CONV, PH_M_WAIT,
		PH_M_RST2, PH_M_SKIP2, PH_M_RSP, PH_M_READ
	} phase_t;

	logic       sensor_enable_q;
	logic [7:0] alarm_high_q;
	logic [7:0] alarm_low_q;
	logic [3:0] resolution_bits_q;
	logic [9:0] convert_wait_ticks_q;
	logic [7:0] family_code_q;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic       presence_s1;
	logic [7:0] read_value_s1;

	phase_t      phase_q, phase_n;
	logic [3:0]  byte_index_q, byte_index_n;
	logic [7:0]  running_crc_q, running_crc_n;
	logic [7:0]  low_byte_q, low_byte_n;
	logic [7:0]  high_byte_q, high_byte_n;
	logic [9:0]  wait_count_q, wait_count_n;
	logic [15:0] last_good_q, last_good_n;

	logic        out_valid_q;
	logic [1:0]  action_q;
	logic [7:0]  write_value_q;
	logic [15:0] temperature_q;
	logic [2:0]  status_q;

	logic        adv;
	logic        emit;
	logic [1:0]  act;
	logic [7:0]  wv;
	logic [2:0]  st;
	logic [9:0]  wait_inc;

	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	assign out_valid   = out_valid_q;
	assign action      = action_q;
	assign write_value = write_value_q;
	assign temperature = temperature_q;
	assign status      = status_q;

	assign wait_inc = wait_count_q + 10'd1;

	always_comb begin
		phase_n       = phase_q;
		byte_index_n  = byte_index_q;
		running_crc_n = running_crc_q;
		low_byte_n    = low_byte_q;
		high_byte_n   = high_byte_q;
		wait_count_n  = wait_count_q;
		last_good_n   = last_good_q;
		emit          = 1'b0;
		act           = ACT_RESET;
		wv            = 8'd0;
		st            = ST_OK;
		case (kind_s1)
			KIND_INIT: begin
				if (phase_q == PH_IDLE) begin
					emit = 1'b1;
					if (!sensor_enable_q) begin
						act = ACT_REPORT;
						st  = ST_NOPRES;
					end else begin
						phase_n = PH_I_RST;
					end
				end
			end
			KIND_MEASURE: begin
				if (phase_q == PH_IDLE) begin
					emit    = 1'b1;
					phase_n = PH_M_RST;
				end
			end
			KIND_TICK: begin
				if (phase_q == PH_M_WAIT) begin
					wait_count_n = wait_inc;
					if (wait_inc >= convert_wait_ticks_q) begin
						emit    = 1'b1;
						phase_n = PH_M_RST2;
					end
				end
			end
			default: begin
				case (phase_q)
					PH_I_RST, PH_I_RST2, PH_M_RST: begin
						emit = 1'b1;
						if (!presence_s1) begin
							act     = ACT_REPORT;
							st      = ST_NOPRES;
							phase_n = PH_IDLE;
						end else begin
							act = ACT_WRITE;
							case (phase_q)
								PH_I_RST: begin
									wv      = CMD_READ_ROM;
									phase_n = PH_I_ROMCMD;
								end
								PH_I_RST2: begin
									wv      = CMD_SKIP_ROM;
									phase_n = PH_I_SKIP;
								end
								default: begin
									wv      = CMD_SKIP_ROM;
									phase_n = PH_M_SKIP;
								end
							endcase
						end
					end
					PH_I_ROMCMD: begin
						emit    = 1'b1;
						act     = ACT_READ;
						phase_n = PH_I_FAMILY;
					end
					PH_I_FAMILY: begin
						emit = 1'b1;
						if (read_value_s1 != family_code_q) begin
							act     = ACT_REPORT;
							st      = ST_FAMILY;
							phase_n = PH_IDLE;
						end else begin
							phase_n = PH_I_RST2;
						end
					end
					PH_I_SKIP: begin
						emit    = 1'b1;
						act     = ACT_WRITE;
						wv      = CMD_WRITE_SP;
						phase_n = PH_I_WSP;
					end
					PH_I_WSP: begin
						emit    = 1'b1;
						act     = ACT_WRITE;
						wv      = alarm_high_q;
						phase_n = PH_I_TH;
					end
					PH_I_TH: begin
						emit    = 1'b1;
						act     = ACT_WRITE;
						wv      = alarm_low_q;
						phase_n = PH_I_TL;
					end
					PH_I_TL: begin
						emit    = 1'b1;
						act     = ACT_WRITE;
						wv      = res_byte(resolution_bits_q);
						phase_n = PH_I_CFG;
					end
					PH_I_CFG: begin
						emit    = 1'b1;
						act     = ACT_REPORT;
						st      = ST_INITOK;
						phase_n = PH_IDLE;
					end
					PH_M_SKIP: begin
						emit    = 1'b1;
						act     = ACT_WRITE;
						wv      = CMD_CONVERT;
						phase_n = PH_M_CONV;
					end
					PH_M_CONV: begin
						wait_count_n = 10'd0;
						if (convert_wait_ticks_q == 10'd0) begin
							emit    = 1'b1;
							phase_n = PH_M_RST2;
						end else begin
							phase_n = PH_M_WAIT;
						end
					end
					PH_M_RST2: begin
						emit    = 1'b1;
						act     = ACT_WRITE;
						wv      = CMD_SKIP_ROM;
						phase_n = PH_M_SKIP2;
					end
					PH_M_SKIP2: begin
						emit    = 1'b1;
						act     = ACT_WRITE;
						wv      = CMD_READ_SP;
						phase_n = PH_M_RSP;
					end
					PH_M_RSP: begin
						emit          = 1'b1;
						act           = ACT_READ;
						byte_index_n  = 4'd0;
						running_crc_n = 8'd0;
						phase_n       = PH_M_READ;
					end
					PH_M_READ: begin
						emit = 1'b1;
						if (byte_index_q >= SCRATCH_CRC_IDX) begin
							act     = ACT_REPORT;
							phase_n = PH_IDLE;
							if (read_value_s1 != running_crc_q) begin
								st = ST_CRC;
							end else begin
								st          = ST_OK;
								last_good_n = {high_byte_q, low_byte_q};
							end
						end else begin
							act = ACT_READ;
							if (byte_index_q == 4'd0) begin
								low_byte_n = read_value_s1;
							end
							if (byte_index_q == 4'd1) begin
								high_byte_n = read_value_s1;
							end
							running_crc_n = crc8_step(running_crc_q, read_value_s1);
							byte_index_n  = byte_index_q + 4'd1;
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_enable_q      <= 1'b1;
			alarm_high_q         <= 8'd42;
			alarm_low_q          <= 8'd246;
			resolution_bits_q    <= 4'd12;
			convert_wait_ticks_q <= 10'd750;
			family_code_q        <= 8'd40;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:     sensor_enable_q      <= cfg_data[0];
				REG_ALARM_HIGH: alarm_high_q         <= cfg_data[7:0];
				REG_ALARM_LOW:  alarm_low_q          <= cfg_data[7:0];
				REG_RESOLUTION: resolution_bits_q    <= cfg_data[3:0];
				REG_WAIT:       convert_wait_ticks_q <= cfg_data;
				REG_FAMILY:     family_code_q        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1       <= kind;
			presence_s1   <= presence;
			read_value_s1 <= read_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			byte_index_q  <= 4'd0;
			running_crc_q <= 8'd0;
			low_byte_q    <= 8'd0;
			high_byte_q   <= 8'd0;
			wait_count_q  <= 10'd0;
			last_good_q   <= 16'd0;
			out_valid_q   <= 1'b0;
		end else if (adv) begin
			phase_q       <= phase_n;
			byte_index_q  <= byte_index_n;
			running_crc_q <= running_crc_n;
			low_byte_q    <= low_byte_n;
			high_byte_q   <= high_byte_n;
			wait_count_q  <= wait_count_n;
			last_good_q   <= last_good_n;
			out_valid_q   <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			action_q      <= act;
			write_value_q <= wv;
			temperature_q <= last_good_n;
			status_q      <= st;
		end
	end

	`OWTS_ASSERT_NOW(a_ready_only_on_stall, !in_ready, valid_s1 && out_valid_q && !out_ready)
	`OWTS_ASSERT_NOW(a_status_only_on_report, out_valid_q && action_q != ACT_REPORT,
		status_q == ST_OK)
	`OWTS_ASSERT_NOW(a_value_only_on_write, out_valid_q && action_q != ACT_WRITE,
		write_value_q == 8'd0)
	`OWTS_ASSERT_NOW(a_index_in_range, 1'b1, byte_index_q <= SCRATCH_CRC_IDX)
	`OWTS_ASSERT_NOW(a_good_only_on_ok, !$stable(last_good_q),
		out_valid_q && action_q == ACT_REPORT && status_q == ST_OK)

endmodule

>>> tb/sv/onewire_temp_sensor_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// One-wire temperature sensor sequencer testbench
// Feeds start, reply and tick items shaped as init and measure conversations
// with random content, errors and stray items, under random idling on both
// channels and a long output stall. An item-level predictor of the sequencer
// forms the expected bus commands and reports, checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module onewire_temp_sensor_sequencer_core_tb;
	import owts_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEM_TARGET   = 1650;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 5;
	localparam int PRINT_CAP     = 40;

	typedef enum logic [4:0] {
		S_IDLE,
		S_I_RST, S_I_ROMCMD, S_I_FAMILY, S_I_RST2,
		S_I_SKIP, S_I_WSP, S_I_TH, S_I_TL, S_I_CFG,
		S_M_RST, S_M_SKIP, S_M_CONV, S_M_WAIT,
		S_M_RST2, S_M_SKIP2, S_M_RSP, S_M_READ
	} seq_phase_t;

	typedef struct packed {
		logic [1:0] code;
		logic       pres;
		logic [7:0] byte_in;
	} bus_item_t;

	typedef struct packed {
		logic [1:0]  act;
		logic [7:0]  wval;
		logic [15:0] temp;
		logic [2:0]  stat;
	} bus_out_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [1:0]         kind        = KIND_INIT;
	logic               presence    = 1'b0;
	logic [7:0]         read_value  = 8'h00;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [1:0]         action;
	logic [7:0]         write_value;
	logic signed [15:0] temperature;
	logic [2:0]         status;
	logic               cfg_valid   = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index   = REG_ENABLE;
	logic [9:0]         cfg_data    = 10'd0;

	onewire_temp_sensor_sequencer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.presence    (presence),
		.read_value  (read_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.action      (action),
		.write_value (write_value),
		.temperature (temperature),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// sequencer configuration copy
	logic       cfg_enable   = 1'b1;
	logic [7:0] cfg_alarm_hi = 8'd42;
	logic [7:0] cfg_alarm_lo = 8'd246;
	logic [3:0] cfg_res      = 4'd12;
	logic [9:0] cfg_wait     = 10'd750;
	logic [7:0] cfg_family   = 8'd40;

	// sequencer state copy
	seq_phase_t  seq_phase  = S_IDLE;
	logic [3:0]  byte_idx   = 4'd0;
	logic [7:0]  crc_acc    = 8'h00;
	logic [7:0]  scratch_lo = 8'h00;
	logic [7:0]  scratch_hi = 8'h00;
	logic [9:0]  tick_count = 10'd0;
	logic [15:0] good_temp  = 16'h0000;

	bus_item_t pending_items[$];
	bus_out_t  expected_outputs[$];
	bus_item_t next_item;
	bus_out_t  exp_out;

	int  items_queued   = 0;
	int  items_accepted = 0;
	int  mismatches     = 0;
	int  cycle_count    = 0;
	int  src_gap        = 0;
	int  stall_left     = 0;
	int  hold_left      = 0;
	int  hold_requests  = 0;
	int  holds_served   = 0;
	int  sink_draw;
	bit  src_idle_on    = 1'b1;
	bit  sink_idle_on   = 1'b1;

	function automatic logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] data);
		logic [7:0] acc;
		acc = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			acc = acc[0] ? ((acc >> 1) ^ CRC_POLY_REFL) : (acc >> 1);
		end
		return acc;
	endfunction

	function automatic logic [7:0] resolution_cfg_byte(logic [3:0] bits);
		case (bits)
			RES_9:   return CFG_RES_9;
			RES_10:  return CFG_RES_10;
			RES_11:  return CFG_RES_11;
			default: return CFG_RES_12;
		endcase
	endfunction

	function automatic void emit_out(logic [1:0] act, logic [7:0] wval, logic [2:0] stat);
		bus_out_t o;
		o.act  = act;
		o.wval = wval;
		o.temp = good_temp;
		o.stat = stat;
		expected_outputs.push_back(o);
	endfunction

	function automatic void issue_cmd(seq_phase_t nxt, logic [1:0] act, logic [7:0] wval);
		seq_phase = nxt;
		emit_out(act, wval, ST_OK);
	endfunction

	function automatic void conclude(logic [2:0] stat);
		seq_phase = S_IDLE;
		emit_out(ACT_REPORT, 8'h00, stat);
	endfunction

	function automatic void sequencer_step(logic [1:0] code, logic pres, logic [7:0] rv);
		if (code == KIND_INIT || code == KIND_MEASURE) begin
			if (seq_phase != S_IDLE)
				return;
			if (code == KIND_MEASURE)
				issue_cmd(S_M_RST, ACT_RESET, 8'h00);
			else if (!cfg_enable)
				conclude(ST_NOPRES);
			else
				issue_cmd(S_I_RST, ACT_RESET, 8'h00);
			return;
		end
		if (code == KIND_TICK) begin
			if (seq_phase != S_M_WAIT)
				return;
			tick_count = tick_count + 10'd1;
			if (tick_count >= cfg_wait)
				issue_cmd(S_M_RST2, ACT_RESET, 8'h00);
			return;
		end
		case (seq_phase)
			S_I_RST: begin
				if (!pres) conclude(ST_NOPRES);
				else issue_cmd(S_I_ROMCMD, ACT_WRITE, CMD_READ_ROM);
			end
			S_I_ROMCMD: issue_cmd(S_I_FAMILY, ACT_READ, 8'h00);
			S_I_FAMILY: begin
				if (rv != cfg_family) conclude(ST_FAMILY);
				else issue_cmd(S_I_RST2, ACT_RESET, 8'h00);
			end
			S_I_RST2: begin
				if (!pres) conclude(ST_NOPRES);
				else issue_cmd(S_I_SKIP, ACT_WRITE, CMD_SKIP_ROM);
			end
			S_I_SKIP: issue_cmd(S_I_WSP, ACT_WRITE, CMD_WRITE_SP);
			S_I_WSP:  issue_cmd(S_I_TH, ACT_WRITE, cfg_alarm_hi);
			S_I_TH:   issue_cmd(S_I_TL, ACT_WRITE, cfg_alarm_lo);
			S_I_TL:   issue_cmd(S_I_CFG, ACT_WRITE, resolution_cfg_byte(cfg_res));
			S_I_CFG:  conclude(ST_INITOK);
			S_M_RST: begin
				if (!pres) conclude(ST_NOPRES);
				else issue_cmd(S_M_SKIP, ACT_WRITE, CMD_SKIP_ROM);
			end
			S_M_SKIP: issue_cmd(S_M_CONV, ACT_WRITE, CMD_CONVERT);
			S_M_CONV: begin
				tick_count = 10'd0;
				if (cfg_wait == 10'd0) issue_cmd(S_M_RST2, ACT_RESET, 8'h00);
				else seq_phase = S_M_WAIT;
			end
			S_M_RST2:  issue_cmd(S_M_SKIP2, ACT_WRITE, CMD_SKIP_ROM);
			S_M_SKIP2: issue_cmd(S_M_RSP, ACT_WRITE, CMD_READ_SP);
			S_M_RSP: begin
				byte_idx = 4'd0;
				crc_acc  = 8'h00;
				issue_cmd(S_M_READ, ACT_READ, 8'h00);
			end
			S_M_READ: begin
				if (byte_idx >= SCRATCH_CRC_IDX) begin
					if (rv != crc_acc) begin
						conclude(ST_CRC);
					end else begin
						good_temp = {scratch_hi, scratch_lo};
						conclude(ST_OK);
					end
				end else begin
					if (byte_idx == 4'd0) scratch_lo = rv;
					if (byte_idx == 4'd1) scratch_hi = rv;
					crc_acc  = crc_fold(crc_acc, rv);
					byte_idx = byte_idx + 4'd1;
					issue_cmd(S_M_READ, ACT_READ, 8'h00);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatches < PRINT_CAP)
			$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL onewire_temp_sensor_sequencer_core");
			$finish;
		end
	end

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_gap  <= 0;
		end else begin
			if (in_valid && in_ready) begin
				sequencer_step(kind, presence, read_value);
				items_accepted <= items_accepted + 1;
			end
			if (in_valid && !in_ready) begin
				// hold until transfer
			end else if (src_gap != 0) begin
				src_gap  <= src_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				next_item  = pending_items.pop_front();
				kind       <= next_item.code;
				presence   <= next_item.pres;
				read_value <= next_item.byte_in;
				in_valid   <= 1'b1;
				src_gap    <= src_idle_on ? $urandom_range(0, 9) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch("unexpected result action", action, 0);
				end else begin
					exp_out = expected_outputs.pop_front();
					if (action !== exp_out.act)
						report_mismatch("action", action, exp_out.act);
					if (write_value !== exp_out.wval)
						report_mismatch("write_value", write_value, exp_out.wval);
					if (temperature !== exp_out.temp)
						report_mismatch("temperature", temperature, exp_out.temp);
					if (status !== exp_out.stat)
						report_mismatch("status", status, exp_out.stat);
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_requests != holds_served) begin
				holds_served <= hold_requests;
				hold_left    <= LONG_HOLD;
				out_ready    <= 1'b0;
			end else if (out_valid && out_ready && sink_idle_on) begin
				sink_draw  = $urandom_range(0, 9);
				stall_left <= sink_draw;
				out_ready  <= (sink_draw == 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= (stall_left == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_item(logic [1:0] code, logic pres, logic [7:0] byte_in);
		bus_item_t it;
		it.code    = code;
		it.pres    = pres;
		it.byte_in = byte_in;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// start or tick while a conversation is running: dropped by the sequencer
	task automatic push_stray();
		case ($urandom_range(0, 2))
			0:       push_item(KIND_INIT, 1'($urandom), 8'($urandom));
			1:       push_item(KIND_MEASURE, 1'($urandom), 8'($urandom));
			default: push_item(KIND_TICK, 1'($urandom), 8'($urandom));
		endcase
	endtask

	task automatic queue_init(logic pres1, logic fam_ok, logic pres2, logic noisy);
		logic [7:0] fam;
		push_item(KIND_INIT, 1'($urandom), 8'($urandom));
		if (!cfg_enable)
			return;
		push_item(KIND_REPLY, pres1, 8'($urandom));
		if (!pres1)
			return;
		if (noisy) push_stray();
		push_item(KIND_REPLY, 1'($urandom), 8'($urandom));
		fam = cfg_family;
		if (!fam_ok) begin
			do fam = 8'($urandom); while (fam == cfg_family);
		end
		push_item(KIND_REPLY, 1'($urandom), fam);
		if (!fam_ok)
			return;
		push_item(KIND_REPLY, pres2, 8'($urandom));
		if (!pres2)
			return;
		for (int i = 0; i < 5; i++) begin
			if (noisy && $urandom_range(0, 2) == 0) push_stray();
			push_item(KIND_REPLY, 1'($urandom), 8'($urandom));
		end
	endtask

	task automatic queue_measure(logic pres_ok, logic crc_ok, logic [15:0] reading,
			logic noisy);
		logic [7:0] scratch [9];
		logic [7:0] crc;
		crc = 8'h00;
		push_item(KIND_MEASURE, 1'($urandom), 8'($urandom));
		push_item(KIND_REPLY, pres_ok, 8'($urandom));
		if (!pres_ok)
			return;
		if (noisy) push_stray();
		push_item(KIND_REPLY, 1'($urandom), 8'($urandom));
		push_item(KIND_REPLY, 1'($urandom), 8'($urandom));
		for (int i = 0; i < cfg_wait; i++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				push_item($urandom_range(0, 1) ? KIND_REPLY : KIND_INIT,
					1'($urandom), 8'($urandom));
			push_item(KIND_TICK, 1'($urandom), 8'($urandom));
		end
		push_item(KIND_REPLY, 1'($urandom), 8'($urandom));
		if (noisy) push_stray();
		push_item(KIND_REPLY, 1'($urandom), 8'($urandom));
		push_item(KIND_REPLY, 1'($urandom), 8'($urandom));
		scratch[0] = reading[7:0];
		scratch[1] = reading[15:8];
		for (int i = 2; i < 8; i++)
			scratch[i] = 8'($urandom);
		for (int i = 0; i < 8; i++)
			crc = crc_fold(crc, scratch[i]);
		scratch[8] = crc_ok ? crc : (crc ^ 8'($urandom_range(1, 255)));
		for (int i = 0; i < 9; i++)
			push_item(KIND_REPLY, 1'($urandom), scratch[i]);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (items_accepted != items_queued || expected_outputs.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// drive the sequencer back to idle
	task automatic settle();
		wait_drained();
		while (seq_phase != S_IDLE) begin
			push_item((seq_phase == S_M_WAIT) ? KIND_TICK : KIND_REPLY, 1'b1, 8'($urandom));
			wait_drained();
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENABLE:     cfg_enable   = val[0];
			REG_ALARM_HIGH: cfg_alarm_hi = val[7:0];
			REG_ALARM_LOW:  cfg_alarm_lo = val[7:0];
			REG_RESOLUTION: cfg_res      = val[3:0];
			REG_WAIT:       cfg_wait     = val;
			REG_FAMILY:     cfg_family   = val[7:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic en, logic [7:0] ah, logic [7:0] al, logic [3:0] res,
			logic [9:0] wt, logic [7:0] fam);
		write_reg(REG_ENABLE, {9'd0, en});
		write_reg(REG_ALARM_HIGH, {2'd0, ah});
		write_reg(REG_ALARM_LOW, {2'd0, al});
		write_reg(REG_RESOLUTION, {6'd0, res});
		write_reg(REG_WAIT, wt);
		write_reg(REG_FAMILY, {2'd0, fam});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int phase_no;
		int phase_end;
		int pick;
		logic noisy;
		logic [3:0] res;
		logic [9:0] wt;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-on settings: strays while idle, then a clean init
		push_item(KIND_REPLY, 1'b1, 8'hFF);
		push_item(KIND_TICK, 1'b0, 8'h00);
		queue_init(1'b1, 1'b1, 1'b1, 1'b0);
		settle();

		// zero wait, lowest high alarm, highest low alarm and lowest resolution code
		apply_settings(1'b1, 8'h00, 8'hFF, RES_9, 10'd0, 8'h00);
		queue_measure(1'b1, 1'b1, 16'h7FFF, 1'b0);
		queue_measure(1'b1, 1'b0, 16'h1234, 1'b0);
		queue_init(1'b1, 1'b0, 1'b1, 1'b0);
		queue_init(1'b1, 1'b1, 1'b1, 1'b1);
		settle();

		// disabled, out-of-range resolution, longest wait
		apply_settings(1'b0, 8'hFF, 8'h00, 4'd15, 10'd1023, 8'hFF);
		queue_init(1'b1, 1'b1, 1'b1, 1'b0);
		queue_measure(1'b0, 1'b1, 16'h0000, 1'b0);
		queue_measure(1'b1, 1'b1, 16'h8000, 1'b0);
		settle();

		phase_no = 0;
		while (items_queued < ITEM_TARGET) begin
			res = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(9, 12));
			wt  = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(5, 40))
				: 10'($urandom_range(0, 4));
			apply_settings(($urandom_range(0, 5) != 0), 8'($urandom), 8'($urandom), res, wt,
				8'($urandom));
			src_idle_on  = (phase_no != 1) && ($urandom_range(0, 3) != 0);
			sink_idle_on = (phase_no != 1) && ($urandom_range(0, 3) != 0);
			if (phase_no == 0)
				hold_requests++;
			phase_end = items_queued + 150;
			while (items_queued < phase_end) begin
				pick  = $urandom_range(0, 19);
				noisy = ($urandom_range(0, 3) == 0);
				if (pick < 10) begin
					queue_measure(1'b1, 1'b1, 16'($urandom), noisy);
				end else if (pick < 14) begin
					queue_init(1'b1, 1'b1, 1'b1, noisy);
				end else if (pick == 14) begin
					queue_measure(1'b0, 1'b1, 16'($urandom), noisy);
				end else if (pick == 15) begin
					queue_measure(1'b1, 1'b0, 16'($urandom), noisy);
				end else if (pick == 16) begin
					queue_init(1'b0, 1'b1, 1'b1, noisy);
				end else if (pick == 17) begin
					queue_init(1'b1, 1'b0, 1'b1, noisy);
				end else if (pick == 18) begin
					queue_init(1'b1, 1'b1, 1'b0, noisy);
				end else begin
					repeat ($urandom_range(1, 6))
						push_item(2'($urandom), 1'($urandom), 8'($urandom));
					settle();
				end
			end
			settle();
			phase_no++;
		end

		wait_drained();
		if (mismatches == 0)
			$display("PASS onewire_temp_sensor_sequencer_core");
		else
			$display("FAIL onewire_temp_sensor_sequencer_core");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/owts_pkg.sv
rtl/core/onewire_temp_sensor_sequencer_core.sv
tb/sv/onewire_temp_sensor_sequencer_core_tb.sv
